@@ rtl/pxc_pkg.sv @@
// ----------------------------------------------------------------------------
// pxc_pkg - shared definitions for the src-over pixel compositor
// Pixel layout, register indexes, mode codes and channel blend arithmetic.
// ----------------------------------------------------------------------------
package pxc_pkg;

   localparam int unsigned PixelW   = 32;
   localparam int unsigned ChanW    = 8;
   localparam int unsigned ModeW    = 2;
   localparam int unsigned CsrIdxW  = 1;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned ReqDataW = 2 * PixelW;

   localparam logic [ChanW-1:0] ChanMax   = 8'hff;
   localparam logic [15:0]      RoundBias = 16'd127;

   typedef logic [PixelW-1:0] pixel_type;
   typedef logic [ChanW-1:0]  chan_type;

   // pixel operation codes; code 3 is unassigned and acts as copy
   typedef enum logic [ModeW-1:0] {
      MODE_COPY  = 2'd0,
      MODE_FILL  = 2'd1,
      MODE_BLEND = 2'd2
   } pxc_mode_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_PIXEL_MODE = 1'b0,
      CSR_FILL_COLOR = 1'b1
   } pxc_csr_type;

   // exact floor(x / 255) for x below 65280, where the quotient fits a channel:
   // t = x + 1, q = (t + t/256) / 256
   function automatic chan_type div255(input logic [15:0] x);
      logic [16:0] t;
      logic [16:0] s;
      t = {1'b0, x} + 17'd1;
      s = t + {8'd0, t[16:8]};
      return s[15:8];
   endfunction

   // (s*a + d*(255-a) + 127) / 255, at most 65152 before the divide
   function automatic chan_type mix_channel(input chan_type s, input chan_type d,
                                            input chan_type a);
      logic [15:0] fs;
      logic [15:0] bs;
      fs = {8'd0, s} * {8'd0, a};
      bs = {8'd0, d} * {8'd0, ChanMax - a};
      return div255(fs + bs + RoundBias);
   endfunction

endpackage

@@ rtl/pixel_compositor_src_over.sv @@
// ----------------------------------------------------------------------------
// pixel_compositor_src_over - streaming RGBA8888 compositor
// Copy, constant fill or non-premultiplied src-over on a pixel stream.
// ----------------------------------------------------------------------------
// The block takes one foreground/background pixel pair per transfer and
// returns one destination pixel per transfer, in order, with tlast carried
// along. It sustains one pixel per clock: the input register and the result
// register advance together whenever the output is empty or being drained.
// A pixel taken into the input register stays there until the output can
// move; it is then loaded into the result register, which offers it on
// the output port until taken. The input stalls only when both
// registers hold pixels and the output is stalled. The multiply/add/
// divide-by-255 path per channel between the two registers sets the clock
// period, not the rate. Mode and fill color are written over the csr port
// and must only change while no pixel is in flight. Pixel byte order: byte0
// red, byte1 green, byte2 blue, byte3 alpha. Mode 3 behaves as copy.
// ----------------------------------------------------------------------------
module pixel_compositor_src_over (
   input  logic                          clock,
   input  logic                          reset,
   // config write port
   input  logic                          csr_wen,
   input  logic [pxc_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [pxc_pkg::CsrDataW-1:0]  csr_wdata,
   // pixel pair in
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pxc_pkg::ReqDataW-1:0]  req_tdata,   // [31:0] fore_pixel, [63:32] back_pixel
   input  logic                          req_tlast,   // in_last
   // pixel out
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pxc_pkg::PixelW-1:0]    rsp_tdata,   // [31:0] out_pixel
   output logic                          rsp_tlast    // out_last
);
   import pxc_pkg::*;

   // config registers
   logic [ModeW-1:0] mode_ff;
   logic [ModeW-1:0] mode_in;
   pixel_type        fill_ff;
   pixel_type        fill_in;

   // input stage
   logic      in_valid_ff;
   logic      in_valid_in;
   pixel_type fore_ff;
   pixel_type back_ff;
   logic      last_ff;

   // result stage
   logic      out_valid_ff;
   logic      out_valid_in;
   pixel_type out_px_ff;
   pixel_type out_px_in;
   logic      out_last_ff;

   logic      advance;
   logic      req_xfer;

   // ---- config writes -------------------------------------------------------
   always_comb begin
      mode_in = mode_ff;
      fill_in = fill_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_PIXEL_MODE: mode_in = csr_wdata[ModeW-1:0];
            CSR_FILL_COLOR: fill_in = csr_wdata[PixelW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COPY;
         fill_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         fill_ff <= fill_in;
      end
   end

   // ---- pipeline control ----------------------------------------------------
   // result register moves when empty or being drained; input register
   // accepts whenever it is empty or its pixel moves on this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---- input register ------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         fore_ff <= req_tdata[PixelW-1:0];
         back_ff <= req_tdata[ReqDataW-1:PixelW];
         last_ff <= req_tlast;
      end
   end

   // ---- pixel operation -----------------------------------------------------
   pxc_pixel_op u_op (
      .mode       (mode_ff),
      .fill_color (fill_ff),
      .fore_pixel (fore_ff),
      .back_pixel (back_ff),
      .out_pixel  (out_px_in)
   );

   // ---- result register -----------------------------------------------------
   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_px_ff   <= out_px_in;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_px_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ rtl/pxc_pixel_op.sv @@
// ----------------------------------------------------------------------------
// pxc_pixel_op - per-pixel operation
// Combinational copy, red/blue swapped fill, or src-over blend of one pixel.
// ----------------------------------------------------------------------------
module pxc_pixel_op (
   input  logic [pxc_pkg::ModeW-1:0] mode,
   input  pxc_pkg::pixel_type        fill_color,
   input  pxc_pkg::pixel_type        fore_pixel,
   input  pxc_pkg::pixel_type        back_pixel,
   output pxc_pkg::pixel_type        out_pixel
);
   import pxc_pkg::*;

   chan_type    fa;
   chan_type    ba;
   chan_type    mix_r;
   chan_type    mix_g;
   chan_type    mix_b;
   chan_type    add_a;
   chan_type    sum_a;
   pixel_type   fill_swapped;
   pixel_type   blend_px;

   assign fa = fore_pixel[31:24];
   assign ba = back_pixel[31:24];

   assign mix_r = mix_channel(fore_pixel[7:0],   back_pixel[7:0],   fa);
   assign mix_g = mix_channel(fore_pixel[15:8],  back_pixel[15:8],  fa);
   assign mix_b = mix_channel(fore_pixel[23:16], back_pixel[23:16], fa);

   // back alpha scaled by the uncovered share; the sum never passes 255
   assign add_a = mix_channel(8'd0, ba, fa);
   assign sum_a = fa + add_a;

   assign blend_px     = {sum_a, mix_b, mix_g, mix_r};
   assign fill_swapped = {fill_color[31:24], fill_color[7:0],
                          fill_color[15:8], fill_color[23:16]};

   always_comb begin
      case (mode)
         MODE_FILL:  out_pixel = fill_swapped;
         MODE_BLEND: out_pixel = blend_px;
         default:    out_pixel = back_pixel;
      endcase
   end

endmodule

@@ rtl/pxc_checker.sv @@
// ----------------------------------------------------------------------------
// pxc_checker - port-level checks for the compositor
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
module pxc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [pxc_pkg::PixelW-1:0]    rsp_tdata,
   input logic                          rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // with the output empty the pipeline can always take a pixel
   a_ready_when_empty: assert property (@(posedge clock)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // every new result comes from an input transfer held in the input register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without matching input transfer");

endmodule

bind pixel_compositor_src_over pxc_checker u_pxc_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - stream-level test of the src-over pixel compositor
// A driver pushes foreground/background pixel pairs from a queue and a
// monitor checks every output pixel against a predictor of copy, fill and
// src-over blend. The run covers every mode and several fill words, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
   import pxc_pkg::*;

   localparam int               WatchdogLimit = 5000;  // cycles with no transfer
   localparam int               TailCycles    = 16;    // idle wait before the final report
   localparam int               ReportLimit   = 10;
   localparam logic [ModeW-1:0] ModeSpare     = 2'd3;  // unassigned code, acts as copy

   // one input transfer and one expected output transfer
   typedef struct packed {
      pixel_type fore;
      pixel_type back;
      logic      last;
   } pair_type;

   typedef struct packed {
      pixel_type px;
      logic      last;
   } dest_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_wen    = 1'b0;
   logic [CsrIdxW-1:0]  csr_index  = CSR_PIXEL_MODE;
   logic [CsrDataW-1:0] csr_wdata  = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;   // [31:0] fore_pixel, [63:32] back_pixel
   logic                req_tlast  = 1'b0; // in_last
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [PixelW-1:0]   rsp_tdata;         // [31:0] out_pixel
   logic                rsp_tlast;         // out_last

   // testbench copy of the two registers, as they reset
   logic [ModeW-1:0] cur_mode = MODE_COPY;
   pixel_type        cur_fill = '0;

   pair_type pairs_pending[$];   // stimulus not yet offered
   dest_type dest_due[$];        // predicted pixels, oldest first
   int       pairs_queued  = 0;
   int       pairs_taken   = 0;
   int       mismatches    = 0;
   int       stuck_cycles  = 0;
   int       send_gap_pct  = 0;   // chance in a hundred the sender idles
   int       rsp_stall_pct = 0;   // chance in a hundred the receiver stalls
   int       rsp_hold_left = 0;   // long receiver hold-off, counted by the monitor

   pixel_compositor_src_over dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // non-premultiplied src-over of one color channel, rounded to nearest
   function automatic chan_type over_chan(input chan_type s, input chan_type d,
                                          input chan_type a);
      int unsigned si;
      int unsigned di;
      int unsigned ai;
      si = s;
      di = d;
      ai = a;
      return chan_type'((si * ai + di * (255 - ai) + 127) / 255);
   endfunction

   function automatic pixel_type composite_pixel(input logic [ModeW-1:0] mode,
                                                 input pixel_type fill,
                                                 input pixel_type fore,
                                                 input pixel_type back);
      pixel_type   px;
      int unsigned fa;
      int unsigned ba;
      int unsigned oa;
      case (mode)
         MODE_FILL: begin
            // red and blue bytes trade places, green and alpha stay
            px = {fill[31:24], fill[7:0], fill[15:8], fill[23:16]};
         end
         MODE_BLEND: begin
            fa = fore[31:24];
            ba = back[31:24];
            oa = fa + (ba * (255 - fa) + 127) / 255;
            if (oa > 255) oa = 255;
            px = {chan_type'(oa),
                  over_chan(fore[23:16], back[23:16], fore[31:24]),
                  over_chan(fore[15:8],  back[15:8],  fore[31:24]),
                  over_chan(fore[7:0],   back[7:0],   fore[31:24])};
         end
         default: begin
            // copy, and the unassigned code behaves the same
            px = back;
         end
      endcase
      return px;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offers queued pairs, predicts each one at its transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pair_type nxt;
      dest_type due;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            due.px   = composite_pixel(cur_mode, cur_fill, req_tdata[31:0], req_tdata[63:32]);
            due.last = req_tlast;
            dest_due.push_back(due);
            pairs_taken++;
         end
         // slot is free once the current pair has gone or none is offered
         if (!req_tvalid || req_tready) begin
            if (pairs_pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               nxt = pairs_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {nxt.back, nxt.fore};
               req_tlast  <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each output transfer, drives backpressure
   // ---------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input logic [PixelW-1:0] want,
                                input logic [PixelW-1:0] got);
      if (mismatches < ReportLimit)
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      dest_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (dest_due.size() == 0) begin
               flag_mismatch("unexpected pixel", '0, rsp_tdata);
            end else begin
               want = dest_due.pop_front();
               if (rsp_tdata !== want.px) flag_mismatch("out_pixel", want.px, rsp_tdata);
               if (rsp_tlast !== want.last) begin
                  flag_mismatch("out_last", PixelW'(want.last), PixelW'(rsp_tlast));
               end
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: work outstanding but no transfer on either side for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && (pairs_taken != pairs_queued || dest_due.size() > 0) &&
          !(req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)) begin
         stuck_cycles++;
         if (stuck_cycles >= WatchdogLimit) begin
            $display("Test completed with failures");
            $finish;
         end
      end else begin
         stuck_cycles = 0;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencing
   // ---------------------------------------------------------------------

   // wait until every queued pair has transferred and every pixel came back
   task automatic settle();
      while (pairs_taken != pairs_queued || dest_due.size() != 0) @(posedge clock);
   endtask

   task automatic queue_pair(input pixel_type fore, input pixel_type back, input logic last);
      pair_type p;
      p.fore = fore;
      p.back = back;
      p.last = last;
      pairs_pending.push_back(p);
      pairs_queued++;
   endtask

   // both registers, back to back; the block is idle when this is called
   task automatic configure(input logic [CsrDataW-1:0] mode_word, input pixel_type fill);
      csr_wen   <= 1'b1;
      csr_index <= CSR_PIXEL_MODE;
      csr_wdata <= mode_word;
      @(posedge clock);
      csr_index <= CSR_FILL_COLOR;
      csr_wdata <= fill;
      @(posedge clock);
      csr_wen   <= 1'b0;
      cur_mode = mode_word[ModeW-1:0];
      cur_fill = fill;
   endtask

   // random pairs; foreground alpha leans toward fully clear and fully opaque
   task automatic queue_random(input int n);
      pixel_type fore;
      pixel_type back;
      for (int i = 0; i < n; i++) begin
         fore = $urandom();
         back = $urandom();
         case ($urandom_range(3))
            0: fore[31:24] = 8'h00;
            1: fore[31:24] = 8'hff;
            default: ;
         endcase
         if ($urandom_range(7) == 0) back[31:24] = $urandom_range(1) ? 8'hff : 8'h00;
         queue_pair(fore, back, $urandom_range(7) == 0);
      end
   endtask

   task automatic run_phase(input logic [ModeW-1:0] mode, input pixel_type fill, input int n,
                            input int gap_pct, input int stall_pct);
      settle();
      // junk in the upper bits of the mode word must be dropped
      configure(($urandom() & ~32'h3) | CsrDataW'(mode), fill);
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      queue_random(n);
      settle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: registers still at reset, so copy with a zero fill word
      queue_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
      queue_pair(32'hffff_ffff, 32'hffff_ffff, 1'b1);
      queue_pair(32'hffff_ffff, 32'h0000_0000, 1'b0);
      queue_pair(32'h0000_0000, 32'ha5c3_3c5a, 1'b1);
      settle();

      // fill ignores both pixels
      configure(32'(MODE_FILL), 32'h1122_3344);
      queue_pair(32'hdead_beef, 32'h0bad_f00d, 1'b0);
      queue_pair(32'hffff_ffff, 32'hffff_ffff, 1'b1);
      settle();
      configure(32'hffff_fffc | 32'(MODE_FILL), 32'hffff_ffff);
      queue_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
      settle();

      // blend corners: opaque, clear, half, and channel extremes
      configure(32'(MODE_BLEND), 32'h0000_0000);
      queue_pair(32'hff12_3456, 32'h7f9a_bcde, 1'b0);   // opaque foreground wins
      queue_pair(32'h0012_3456, 32'h7f9a_bcde, 1'b1);   // clear foreground, back alpha kept
      queue_pair(32'h00ff_ffff, 32'h0000_0000, 1'b0);
      queue_pair(32'h80ff_ffff, 32'hff00_0000, 1'b0);
      queue_pair(32'h8000_0000, 32'hffff_ffff, 1'b1);
      queue_pair(32'hff00_0000, 32'hffff_ffff, 1'b0);
      queue_pair(32'h01ff_00ff, 32'hfe00_ff00, 1'b0);
      queue_pair(32'hfe00_ff00, 32'h01ff_00ff, 1'b1);
      queue_pair(32'hffff_ffff, 32'hffff_ffff, 1'b0);
      settle();

      // unassigned mode code falls back to copy
      configure(32'(ModeSpare), 32'h5a5a_a5a5);
      queue_pair(32'h1234_5678, 32'h8765_4321, 1'b0);
      queue_pair(32'hffff_ffff, 32'h0000_0000, 1'b1);
      settle();

      // random part
      run_phase(MODE_BLEND, $urandom(),   150,  0,  0);   // no idling
      run_phase(MODE_BLEND, $urandom(),   120, 50,  0);   // sender idles
      run_phase(MODE_COPY,  $urandom(),    80,  0, 50);   // receiver stalls
      run_phase(MODE_BLEND, $urandom(),   120, 13, 13);
      run_phase(MODE_FILL,  $urandom(),    60,  0, 50);
      run_phase(ModeSpare,  32'h0000_0000, 50, 50, 50);
      run_phase(MODE_FILL,  32'hffff_ffff, 20, 13, 13);

      // receiver holds off long enough for the block to fill and stall its input
      settle();
      configure(32'(MODE_BLEND), 32'h0000_0000);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 300;
      queue_random(100);
      settle();

      // sender pauses mid-stream until the block has drained
      send_gap_pct  = 13;
      rsp_stall_pct = 13;
      queue_random(40);
      settle();
      queue_random(40);
      settle();

      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0 && dest_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/pxc_pkg.sv
rtl/pxc_pixel_op.sv
rtl/pixel_compositor_src_over.sv
rtl/pxc_checker.sv
bench/tb.sv
